// ----- hw/rtl/smsc_pkg.sv -----
// ----------------------------------------------------------------------------
// smsc_pkg
// Shared types and constants of the sliding-mode speed controller.
// ----------------------------------------------------------------------------
`default_nettype none

package smsc_pkg;

    localparam int IN_W      = 16;
    localparam int ERR_W     = 17;
    localparam int INT_W     = 40;
    localparam int GAIN_W    = 32;
    localparam int LIM_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    // operands are sign-extended to the integral width and shifted out one bit a beat
    localparam int OPW      = INT_W;
    localparam int ACC_W    = 36;
    localparam int N_TERMS  = 3;
    localparam int CNT_W    = $clog2(OPW);
    localparam int SW_EXTRA = 2;

    localparam logic BOUNDARY_LAYER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SURF_ERR_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SURF_INT_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_ERROR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_INTEG   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_SPEED   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_SWITCH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX       = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAIN,
        ST_SW_SEL,
        ST_TERM,
        ST_SUM,
        ST_LIMIT
    } t_state;

    typedef struct packed {
        logic clr;
        logic step;
        logic last;
    } t_mac_ctl;

    typedef struct packed {
        t_mac_ctl mac_s;
        t_mac_ctl mac_c;
        logic     load;
        logic     rotate;
        logic     sel_sw;
        logic     term;
        logic     sum;
        logic     fin;
        logic     ready;
    } t_seq_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/smsc_mac.sv -----
// ----------------------------------------------------------------------------
// smsc_mac
// Serial-parallel multiply-accumulate lane: parallel coefficients, operand
// bits LSB first, sign bit subtracted on the last beat.
// ----------------------------------------------------------------------------
`default_nettype none

module smsc_mac import smsc_pkg::*; (
    input  wire logic                           i_clk,
    input  wire t_mac_ctl                       i_ctl,
    input  wire logic [N_TERMS-1:0][GAIN_W-1:0] i_coef,
    input  wire logic [N_TERMS-1:0]             i_bit,
    output logic signed [ACC_W-1:0]             o_hi,
    output logic [OPW-1:0]                      o_lo
);

    logic signed [ACC_W-1:0] r_hi, n_hi;
    logic [OPW-1:0]          r_lo, n_lo;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] acc_sum;

    always_comb begin
        term = '0;
        for (int j = 0; j < N_TERMS; j++) begin
            if (i_bit[j]) begin
                term = term + ACC_W'($signed(i_coef[j]));
            end
        end
        acc_sum = i_ctl.last ? (r_hi - term) : (r_hi + term);
        n_hi    = acc_sum >>> 1;
        n_lo    = {acc_sum[0], r_lo[OPW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_hi <= '0;
        end else if (i_ctl.step) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_hi = r_hi;
    assign o_lo = r_lo;

endmodule

`default_nettype wire

// ----- hw/rtl/smsc_seq.sv -----
// ----------------------------------------------------------------------------
// smsc_seq
// Sequencer: operand pass, switching selection, switching-term pass, final
// sum and output limiting.
// ----------------------------------------------------------------------------
`default_nettype none

module smsc_seq import smsc_pkg::*; #(
    parameter int SW_W = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_free,
    output t_seq_ctl  o_ctl
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ctl.ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load      = 1'b1;
                    o_ctl.mac_s.clr = 1'b1;
                    o_ctl.mac_c.clr = 1'b1;
                    n_cnt           = '0;
                    n_state         = ST_MAIN;
                end
            end
            ST_MAIN: begin
                o_ctl.rotate     = 1'b1;
                o_ctl.mac_s.step = 1'b1;
                o_ctl.mac_c.step = 1'b1;
                o_ctl.mac_s.last = (r_cnt == CNT_W'(OPW - 1));
                o_ctl.mac_c.last = (r_cnt == CNT_W'(OPW - 1));
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(OPW - 1)) begin
                    n_state = ST_SW_SEL;
                end
            end
            ST_SW_SEL: begin
                o_ctl.sel_sw    = 1'b1;
                o_ctl.mac_s.clr = 1'b1;
                n_cnt           = '0;
                n_state         = ST_TERM;
            end
            ST_TERM: begin
                o_ctl.term       = 1'b1;
                o_ctl.mac_s.step = 1'b1;
                o_ctl.mac_s.last = (r_cnt == CNT_W'(SW_W - 1));
                n_cnt            = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SW_W - 1)) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_ctl.sum = 1'b1;
                n_state   = ST_LIMIT;
            end
            ST_LIMIT: begin
                if (i_out_free) begin
                    o_ctl.fin = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_mode_speed_controller.sv -----
// ----------------------------------------------------------------------------
// sliding_mode_speed_controller
// Sliding-mode speed loop: error, saturating integral, sliding surface with
// boundary layer, linear command mix and output limiting, in bit-serial form.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream beat carries speed_ref and speed_meas; one master stream beat returns
//   current_cmd and the limited flag for every input beat. Configuration writes go over
//   the cfg channel (ready outside reset); the user must write while idle (not enforced).
// Sequence:
//   The operand pass shifts the error, integral and speed through two serial
//   MAC lanes; the switching value is then selected from the surface, the
//   switching term is formed on the surface lane, and the final sum and
//   limiting follow. One item is in flight at a time; the next input beat is
//   taken only once the result has entered the output register.
// Reset: synchronous active low; clears integral, previous error, gains and
//   sets the command limits to the full 16-bit range. No beat is taken while
//   reset is held.
// Stall: a result waiting on i_m_axis_tready holds the block in the limiting
//   step; the integral commits only when the result enters the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_mode_speed_controller import smsc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [31:0]          i_s_axis_tdata,   // [15:0] speed_ref, [31:16] speed_meas
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [15:0]               o_m_axis_tdata,   // [15:0] current_cmd
    output logic [0:0]                o_m_axis_tuser,   // [0] limited
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int SW_W = FRAC_BITS + SW_EXTRA;
    localparam int S_W  = ACC_W + OPW;
    localparam int T_W  = ACC_W + SW_EXTRA;
    localparam int Q_W  = S_W - FRAC_BITS;

    t_seq_ctl seq_ctl;
    logic     out_free;

    logic signed [GAIN_W-1:0] r_surf_err_gain, r_surf_int_gain;
    logic signed [GAIN_W-1:0] r_coeff_error, r_coeff_integ, r_coeff_speed, r_coeff_switch;
    logic signed [LIM_W-1:0]  r_out_min, r_out_max;

    logic signed [INT_W-1:0]  r_integral;
    logic signed [ERR_W-1:0]  r_prev_err;

    logic [OPW-1:0]           r_e_sh, r_trial_sh, r_meas_sh;
    logic [SW_W-1:0]          r_sw_sh;
    logic signed [Q_W-1:0]    r_q;

    logic                     r_out_valid;
    logic [LIM_W-1:0]         r_cmd;
    logic                     r_lim;

    logic signed [IN_W-1:0]   speed_ref, speed_meas;
    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W:0]    int_sum;
    logic signed [INT_W-1:0]  trial;

    logic [N_TERMS-1:0][GAIN_W-1:0] coef_s, coef_c;
    logic [N_TERMS-1:0]             bit_s, bit_c;
    logic signed [ACC_W-1:0]        hi_s, hi_c;
    logic [OPW-1:0]                 lo_s, lo_c;

    logic signed [S_W-1:0]    surf;
    logic signed [S_W-1:0]    one_s, neg_one_s;
    logic [SW_W-1:0]          one_sw;
    logic [SW_W-1:0]          sw;
    logic signed [T_W-1:0]    t_term;
    logic signed [S_W-1:0]    mix_sum;
    logic signed [Q_W-1:0]    q_hi_lim, q_lo_lim;
    logic [LIM_W-1:0]         cmd;
    logic                     lim;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = seq_ctl.ready && i_rst_n;
    assign o_cfg_ready     = i_rst_n;

    smsc_seq #(
        .SW_W (SW_W)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_out_free (out_free),
        .o_ctl      (seq_ctl)
    );

    // operand front end
    always_comb begin
        speed_ref  = $signed(i_s_axis_tdata[15:0]);
        speed_meas = $signed(i_s_axis_tdata[31:16]);
        err        = ERR_W'(speed_ref) - ERR_W'(speed_meas);
        int_sum    = (INT_W + 1)'(r_integral) + (INT_W + 1)'(r_prev_err);
        if (int_sum[INT_W] != int_sum[INT_W-1]) begin
            trial = {int_sum[INT_W], {(INT_W - 1){~int_sum[INT_W]}}};
        end else begin
            trial = int_sum[INT_W-1:0];
        end
    end

    // lane operand selection
    always_comb begin
        coef_c = {r_coeff_speed, r_coeff_integ, r_coeff_error};
        bit_c  = {r_meas_sh[0], r_trial_sh[0], r_e_sh[0]};
        if (seq_ctl.term) begin
            coef_s = {GAIN_W'(0), GAIN_W'(0), r_coeff_switch};
            bit_s  = {1'b0, 1'b0, r_sw_sh[0]};
        end else begin
            coef_s = {GAIN_W'(0), r_surf_int_gain, r_surf_err_gain};
            bit_s  = {1'b0, r_trial_sh[0], r_e_sh[0]};
        end
    end

    smsc_mac u_mac_s (
        .i_clk  (i_clk),
        .i_ctl  (seq_ctl.mac_s),
        .i_coef (coef_s),
        .i_bit  (bit_s),
        .o_hi   (hi_s),
        .o_lo   (lo_s)
    );

    smsc_mac u_mac_c (
        .i_clk  (i_clk),
        .i_ctl  (seq_ctl.mac_c),
        .i_coef (coef_c),
        .i_bit  (bit_c),
        .o_hi   (hi_c),
        .o_lo   (lo_c)
    );

    // switching value, final sum and limits
    always_comb begin
        surf      = {hi_s, lo_s};
        one_s     = S_W'(1) <<< FRAC_BITS;
        neg_one_s = -one_s;
        one_sw    = SW_W'(1) << FRAC_BITS;
        if (BOUNDARY_LAYER) begin
            if (surf > one_s) begin
                sw = one_sw;
            end else if (surf < neg_one_s) begin
                sw = -one_sw;
            end else begin
                sw = surf[SW_W-1:0];
            end
        end else begin
            if (surf[S_W-1]) begin
                sw = -one_sw;
            end else if (surf == '0) begin
                sw = '0;
            end else begin
                sw = one_sw;
            end
        end

        t_term  = {hi_s, lo_s[OPW-1 -: SW_EXTRA]};
        mix_sum = $signed({hi_c, lo_c}) + S_W'(t_term);

        q_hi_lim = Q_W'(r_out_max);
        q_lo_lim = Q_W'(r_out_min);
        if (r_q > q_hi_lim) begin
            cmd = r_out_max;
            lim = 1'b1;
        end else if (r_q < q_lo_lim) begin
            cmd = r_out_min;
            lim = 1'b1;
        end else begin
            cmd = r_q[LIM_W-1:0];
            lim = 1'b0;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_err_gain <= '0;
            r_surf_int_gain <= '0;
            r_coeff_error   <= '0;
            r_coeff_integ   <= '0;
            r_coeff_speed   <= '0;
            r_coeff_switch  <= '0;
            r_out_min       <= 16'sh8000;
            r_out_max       <= 16'sh7FFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SURF_ERR_GAIN: r_surf_err_gain <= i_cfg_data;
                REG_SURF_INT_GAIN: r_surf_int_gain <= i_cfg_data;
                REG_COEFF_ERROR:   r_coeff_error   <= i_cfg_data;
                REG_COEFF_INTEG:   r_coeff_integ   <= i_cfg_data;
                REG_COEFF_SPEED:   r_coeff_speed   <= i_cfg_data;
                REG_COEFF_SWITCH:  r_coeff_switch  <= i_cfg_data;
                REG_OUT_MIN:       r_out_min       <= i_cfg_data[LIM_W-1:0];
                REG_OUT_MAX:       r_out_max       <= i_cfg_data[LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // operand shift registers and working values
    always_ff @(posedge i_clk) begin
        if (seq_ctl.load) begin
            r_e_sh     <= OPW'(err);
            r_trial_sh <= OPW'(trial);
            r_meas_sh  <= OPW'(speed_meas);
        end else if (seq_ctl.rotate) begin
            r_e_sh     <= {r_e_sh[0], r_e_sh[OPW-1:1]};
            r_trial_sh <= {r_trial_sh[0], r_trial_sh[OPW-1:1]};
            r_meas_sh  <= {r_meas_sh[0], r_meas_sh[OPW-1:1]};
        end
        if (seq_ctl.sel_sw) begin
            r_sw_sh <= sw;
        end else if (seq_ctl.term) begin
            r_sw_sh <= {r_sw_sh[SW_W-1], r_sw_sh[SW_W-1:1]};
        end
        if (seq_ctl.sum) begin
            r_q <= mix_sum[S_W-1:FRAC_BITS];
        end
        if (seq_ctl.fin) begin
            r_cmd <= cmd;
            r_lim <= lim;
        end
    end

    // controller state and output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral  <= '0;
            r_prev_err  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (seq_ctl.fin) begin
                r_prev_err <= r_e_sh[ERR_W-1:0];
                if (!lim) begin
                    r_integral <= r_trial_sh;
                end
            end
            if (seq_ctl.fin) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_cmd;
    assign o_m_axis_tuser  = r_lim;

endmodule

`default_nettype wire

// ----- hw/rtl/smsc_checker.sv -----
// ----------------------------------------------------------------------------
// smsc_checker
// Port-level checks of the speed controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module smsc_checker (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [15:0]          o_m_axis_tdata,
    input wire logic [0:0]           o_m_axis_tuser,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready
);

    logic in_beat;

    assign in_beat = i_s_axis_tvalid && o_s_axis_tready;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    a_result_on_return: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_s_axis_tready) && $past(i_rst_n) |-> o_m_axis_tvalid)
        else $error("block went idle without presenting a result");

    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> o_s_axis_tready)
        else $error("register written while an item is in flight");

endmodule

bind sliding_mode_speed_controller smsc_checker u_smsc_checker (.*);

`default_nettype wire
